@@ design/line_pixel_generator_core_assert.svh @@
// assertion macros for the line pixel generator checker
// expects signals named clk and rst in the scope of use
`ifndef LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define LPG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define LPG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lpg_pkg.sv @@
// shared constants and control structs for the line pixel generator
// no dependencies
package lpg_pkg;

  localparam int COORD_BITS_DEF = 6;   // default coordinate width
  localparam int FIELD_BITS     = 6;   // width of coordinate fields on the ports
  localparam int COLOR_BITS     = 8;
  localparam int CFG_IDX_BITS   = 2;
  localparam int IN_DATA_BITS   = 24;  // four coordinates
  localparam int OUT_DATA_BITS  = 40;  // 36 payload bits padded to bytes

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_RED   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GREEN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLUE  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new segment
    logic emit;   // push current pixel to output register and advance
  } lpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a pixel this cycle
    logic final_pix;  // current pixel is the segment's last
  } lpg_sts_t;

endpackage

@@ design/lpg_ctrl.sv @@
// segment sequencer: idle / run state machine
// depends on lpg_pkg
module lpg_ctrl
  import lpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lpg_sts_t sts,
  output lpg_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign in_ready = (state == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.emit = (state == ST_RUN) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.emit && sts.final_pix) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/lpg_datapath.sv @@
// segment setup, incremental rounded stepping, color registers, output register
// depends on lpg_pkg
module lpg_datapath
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lpg_cmd_t                cmd,
  output lpg_sts_t                sts,
  input  logic [FIELD_BITS-1:0]   x_start,
  input  logic [FIELD_BITS-1:0]   y_start,
  input  logic [FIELD_BITS-1:0]   x_end,
  input  logic [FIELD_BITS-1:0]   y_end,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COLOR_BITS-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FIELD_BITS-1:0]   pixel_x,
  output logic [FIELD_BITS-1:0]   pixel_y,
  output logic [COLOR_BITS-1:0]   red_out,
  output logic [COLOR_BITS-1:0]   green_out,
  output logic [COLOR_BITS-1:0]   blue_out,
  output logic                    last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int RW = COORD_BITS + 3;  // remainder plus one step, signed

  // setup
  logic [CB-1:0]        xs, ys, xe, ye;
  logic signed [CB:0]   dx, dy, adx_full, ady_full, dmin;
  logic [CB-1:0]        adx, ady, len;
  logic                 shallow, dir_neg;

  // walk state
  logic [CB-1:0]        cur_x, cur_y, count, len_q;
  logic signed [CB:0]   dmin_q;
  logic signed [RW-1:0] rem, r_sum, rem_next, two_len, two_dmin;
  logic                 shallow_q, dir_neg_q;
  logic [CB-1:0]        major, minor, major_next, minor_next;

  logic [COLOR_BITS-1:0] red_level, green_level, blue_level;

  always_comb begin
    xs = x_start[CB-1:0];
    ys = y_start[CB-1:0];
    xe = x_end[CB-1:0];
    ye = y_end[CB-1:0];
    dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
    dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
    adx_full = dx[CB] ? -dx : dx;
    ady_full = dy[CB] ? -dy : dy;
    adx = adx_full[CB-1:0];
    ady = ady_full[CB-1:0];
    shallow = (adx >= ady);
    len     = shallow ? adx : ady;
    dir_neg = shallow ? dx[CB] : dy[CB];
    dmin    = shallow ? dy : dx;
  end

  // rounded minor coordinate kept as quotient plus remainder in [0, 2*len)
  always_comb begin
    two_len  = $signed({{(RW-CB-1){1'b0}}, len_q, 1'b0});
    two_dmin = $signed({{(RW-CB-2){dmin_q[CB]}}, dmin_q, 1'b0});
    r_sum    = rem + two_dmin;
    major    = shallow_q ? cur_x : cur_y;
    minor    = shallow_q ? cur_y : cur_x;
    major_next = dir_neg_q ? major - 1'b1 : major + 1'b1;
    minor_next = minor;
    rem_next   = r_sum;
    priority if (r_sum >= two_len) begin
      minor_next = minor + 1'b1;
      rem_next   = r_sum - two_len;
    end else if (r_sum < 0) begin
      minor_next = minor - 1'b1;
      rem_next   = r_sum + two_len;
    end
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.final_pix = (count == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x     <= xs;
      cur_y     <= ys;
      count     <= len;
      len_q     <= len;
      dmin_q    <= dmin;
      rem       <= $signed({{(RW-CB){1'b0}}, len});
      shallow_q <= shallow;
      dir_neg_q <= dir_neg;
    end else if (cmd.emit) begin
      count <= count - 1'b1;
      rem   <= rem_next;
      if (shallow_q) begin
        cur_x <= major_next;
        cur_y <= minor_next;
      end else begin
        cur_y <= major_next;
        cur_x <= minor_next;
      end
    end
  end

  // color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red_level   <= '0;
      green_level <= '0;
      blue_level  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_RED)   red_level   <= cfg_data;
      if (cfg_index == REG_GREEN) green_level <= cfg_data;
      if (cfg_index == REG_BLUE)  blue_level  <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x    <= FIELD_BITS'(cur_x);
      pixel_y    <= FIELD_BITS'(cur_y);
      red_out    <= red_level;
      green_out  <= green_level;
      blue_out   <= blue_level;
      last_pixel <= sts.final_pix;
    end
  end

endmodule

@@ design/line_pixel_generator_core.sv @@
// line pixel generator top level: stream ports, controller and datapath
// depends on lpg_pkg, lpg_ctrl, lpg_datapath
//
//  channel   | direction | transaction carries
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one segment: x_start, y_start, x_end, y_end
//  m_axis    | out       | one pixel: x, y, red, green, blue; tlast on final
//  cfg       | in        | write of one color register (red, green, blue)
//
// a segment of n = max(|dx|,|dy|) + 1 pixels is handled as a setup step (load),
// then one pixel per cycle from the stepping loop while the output register is free
// the next segment is taken the cycle after its predecessor's last pixel is loaded
// a stalled m_axis holds the walk; the pixel waiting in the output register does
// not block acceptance of the next segment
// synchronous active-high reset clears the state machine, output valid and colors
module line_pixel_generator_core
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // pixel_x[5:0], pixel_y[11:6], red_out[19:12], green_out[27:20],
  // blue_out[35:28], zero pad [39:36]
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic                     m_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [COLOR_BITS-1:0]    cfg_data
);

  lpg_cmd_t cmd;
  lpg_sts_t sts;

  logic [FIELD_BITS-1:0] pixel_x, pixel_y;
  logic [COLOR_BITS-1:0] red_out, green_out, blue_out;

  // sequencer: accepts a segment when idle, emits while the output slot is free
  lpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // setup, stepping, colors and the output register
  lpg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .x_start    (s_tdata[5:0]),
    .y_start    (s_tdata[11:6]),
    .x_end      (s_tdata[17:12]),
    .y_end      (s_tdata[23:18]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .last_pixel (m_tlast)
  );

  // pack the pixel, padding to whole bytes
  assign m_tdata = {4'b0000, blue_out, green_out, red_out, pixel_y, pixel_x};

endmodule

@@ design/lpg_checker.sv @@
// port-level checks for the line pixel generator, bound to the top level
// depends on lpg_pkg and line_pixel_generator_core_assert.svh
`include "line_pixel_generator_core_assert.svh"

module lpg_checker
  import lpg_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic                     m_tlast,
  input logic                     m_tvalid,
  input logic                     m_tready
);

  logic                  prev_cont;
  logic [FIELD_BITS:0]   prev_x, prev_y, cur_x, cur_y;
  logic                  out_xfer, x_near, y_near;

  assign out_xfer = m_tvalid && m_tready;
  assign cur_x    = {1'b0, m_tdata[5:0]};
  assign cur_y    = {1'b0, m_tdata[11:6]};
  assign x_near   = (cur_x == prev_x) || (cur_x == prev_x + 1'b1) || (prev_x == cur_x + 1'b1);
  assign y_near   = (cur_y == prev_y) || (cur_y == prev_y + 1'b1) || (prev_y == cur_y + 1'b1);

  // remember the last delivered pixel while a segment is still running
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cont <= 1'b0;
    end else if (out_xfer) begin
      prev_cont <= !m_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

  // a taken segment keeps the input closed for at least its first pixel
  `LPG_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "segment accept not followed by busy")

  // a stalled pixel holds
  `LPG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed under stall")

  // neighboring pixels of one segment touch
  `LPG_ASSERT_NOW(a_adjacent, out_xfer && prev_cont, x_near && y_near, "pixel gap inside segment")

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (.*);
